[hdl/btdr_pkg.sv]
// Shared types and constants for the banked tile map with dirty marks.
// Used by btdr_ctrl and banked_tilemap_dirty_refresh_top.
`default_nettype none

package btdr_pkg;

   localparam int COLUMNS_DEFAULT = 40;
   localparam int ROWS_DEFAULT    = 25;

   localparam int TILE_W  = 16;
   localparam int ENTRY_W = TILE_W + 1;
   localparam int DIRTY_BIT = TILE_W;
   localparam int SET_BIT   = 9;
   localparam int CODE_W    = 9;
   localparam int CELL_SHIFT = 3;

   localparam logic [9:0] CLEAR_OFFSET = 10'h3ff;

   typedef enum logic [1:0] {
      CMD_TILE_WRITE = 2'd0,
      CMD_BANK_WRITE = 2'd1,
      CMD_REFRESH    = 2'd2,
      CMD_UNUSED     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_WR_CHECK,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic       valid;
      logic       gfx_set;
      logic [8:0] tile_code;
      logic [8:0] x_pos;
      logic [7:0] y_pos;
      logic       last;
   } draw_type;

endpackage

`default_nettype wire

[hdl/btdr_tile_ram.sv]
// Tile entry memory: one write port, one read port, registered read data.
// Each entry holds the dirty mark above the 16-bit tile value; no package use.
`default_nettype none

module btdr_tile_ram #(
   parameter int DEPTH  = 1000,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 17
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[hdl/btdr_ctrl.sv]
// Sequencer for tile writes, bank writes, screen clears and row refreshes.
// Depends on btdr_pkg and drives the ports of btdr_tile_ram.
`default_nettype none

module btdr_ctrl #(
   parameter int COLUMNS    = btdr_pkg::COLUMNS_DEFAULT,
   parameter int ROWS       = btdr_pkg::ROWS_DEFAULT,
   parameter int TILE_COUNT = COLUMNS * ROWS,
   parameter int ADDR_W     = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_cmd,
   input  wire logic [9:0]                     req_offset,
   input  wire logic [7:0]                     req_data,
   input  wire logic [4:0]                     req_row,
   input  wire logic                           req_force_all,
   input  wire logic                           out_ready,
   output btdr_pkg::draw_type                  push,
   output logic                                mem_we,
   output logic [ADDR_W-1:0]                   mem_waddr,
   output logic [btdr_pkg::ENTRY_W-1:0]        mem_wdata,
   output logic                                mem_re,
   output logic [ADDR_W-1:0]                   mem_raddr,
   input  wire logic [btdr_pkg::ENTRY_W-1:0]   mem_rdata
);

   localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TILE_COUNT - 1);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

   btdr_pkg::state_type state_ff, state_in;
   btdr_pkg::draw_type  pend_ff, pend_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [7:0]          bank_ff, bank_in;
   logic [btdr_pkg::TILE_W-1:0] nv_ff, nv_in;
   logic [4:0]          row_ff, row_in;
   logic                force_ff, force_in;

   btdr_pkg::cmd_type   cmd;
   logic                accept;
   logic                is_tile;
   logic                is_clear;
   logic                row_ok;
   logic [ADDR_W-1:0]   base_addr;
   logic                flagged;
   logic                can_go;
   btdr_pkg::draw_type  cur_draw;

   assign cmd       = btdr_pkg::cmd_type'(req_cmd);
   assign req_stall = (state_ff != btdr_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_tile   = (32'(req_offset) < TILE_COUNT);
   assign is_clear  = !is_tile && (req_offset == btdr_pkg::CLEAR_OFFSET);
   assign row_ok    = (32'(req_row) < ROWS);
   assign base_addr = ADDR_W'(32'(req_row) * COLUMNS);
   assign flagged   = force_ff || mem_rdata[btdr_pkg::DIRTY_BIT];
   assign can_go    = !flagged || !pend_ff.valid || out_ready;

   always_comb begin
      cur_draw           = '0;
      cur_draw.valid     = 1'b1;
      cur_draw.gfx_set   = mem_rdata[btdr_pkg::SET_BIT];
      cur_draw.tile_code = mem_rdata[btdr_pkg::CODE_W-1:0];
      cur_draw.x_pos     = 9'(32'(col_ff) << btdr_pkg::CELL_SHIFT);
      cur_draw.y_pos     = 8'(32'(row_ff) << btdr_pkg::CELL_SHIFT);
      cur_draw.last      = 1'b0;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         btdr_pkg::ST_SWEEP: begin
            if (addr_ff == LAST_ADDR) begin
               state_in = btdr_pkg::ST_IDLE;
            end
         end
         btdr_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (cmd == btdr_pkg::CMD_TILE_WRITE && is_tile) begin
                  state_in = btdr_pkg::ST_WR_CHECK;
               end else if (cmd == btdr_pkg::CMD_TILE_WRITE && is_clear) begin
                  state_in = btdr_pkg::ST_SWEEP;
               end else if (cmd == btdr_pkg::CMD_REFRESH && row_ok) begin
                  state_in = btdr_pkg::ST_SCAN;
               end else begin
                  state_in = btdr_pkg::ST_IDLE;
               end
            end
         end
         btdr_pkg::ST_WR_CHECK: begin
            state_in = btdr_pkg::ST_IDLE;
         end
         btdr_pkg::ST_SCAN: begin
            if (can_go && col_ff == LAST_COL) begin
               state_in = btdr_pkg::ST_FLUSH;
            end
         end
         btdr_pkg::ST_FLUSH: begin
            if (!pend_ff.valid || out_ready) begin
               state_in = btdr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = btdr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pend_in   = pend_ff;
      addr_in   = addr_ff;
      col_in    = col_ff;
      bank_in   = bank_ff;
      nv_in     = nv_ff;
      row_in    = row_ff;
      force_in  = force_ff;
      push      = '0;
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = addr_ff;
      unique case (state_ff)
         btdr_pkg::ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, {btdr_pkg::TILE_W{1'b0}}};
            addr_in   = addr_ff + 1'b1;
         end
         btdr_pkg::ST_IDLE: begin
            if (accept) begin
               nv_in    = {bank_ff, req_data};
               row_in   = req_row;
               force_in = req_force_all;
               col_in   = '0;
               pend_in  = '0;
               priority if (cmd == btdr_pkg::CMD_TILE_WRITE && is_tile) begin
                  addr_in   = ADDR_W'(req_offset);
                  mem_re    = 1'b1;
                  mem_raddr = ADDR_W'(req_offset);
               end else if (cmd == btdr_pkg::CMD_TILE_WRITE && is_clear) begin
                  addr_in = '0;
               end else if (cmd == btdr_pkg::CMD_BANK_WRITE) begin
                  bank_in = req_data;
               end else if (cmd == btdr_pkg::CMD_REFRESH && row_ok) begin
                  addr_in   = base_addr;
                  mem_re    = 1'b1;
                  mem_raddr = base_addr;
               end else begin
                  addr_in = addr_ff;
               end
            end
         end
         btdr_pkg::ST_WR_CHECK: begin
            if (mem_rdata[btdr_pkg::TILE_W-1:0] != nv_ff) begin
               mem_we    = 1'b1;
               mem_wdata = {1'b1, nv_ff};
            end
         end
         btdr_pkg::ST_SCAN: begin
            if (can_go) begin
               if (flagged) begin
                  mem_we    = 1'b1;
                  mem_wdata = {1'b0, mem_rdata[btdr_pkg::TILE_W-1:0]};
                  push      = pend_ff;
                  pend_in   = cur_draw;
               end
               if (col_ff != LAST_COL) begin
                  col_in    = col_ff + 1'b1;
                  addr_in   = addr_ff + 1'b1;
                  mem_re    = 1'b1;
                  mem_raddr = addr_ff + 1'b1;
               end
            end
         end
         btdr_pkg::ST_FLUSH: begin
            if (pend_ff.valid && out_ready) begin
               push      = pend_ff;
               push.last = 1'b1;
               pend_in   = '0;
            end
         end
         default: begin
            pend_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= btdr_pkg::ST_SWEEP;
         addr_ff       <= '0;
         bank_ff       <= '0;
         pend_ff.valid <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         bank_ff       <= bank_in;
         pend_ff.valid <= pend_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff.gfx_set   <= pend_in.gfx_set;
      pend_ff.tile_code <= pend_in.tile_code;
      pend_ff.x_pos     <= pend_in.x_pos;
      pend_ff.y_pos     <= pend_in.y_pos;
      pend_ff.last      <= pend_in.last;
      col_ff            <= col_in;
      nv_ff             <= nv_in;
      row_ff            <= row_in;
      force_ff          <= force_in;
   end

   a_push_ready: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> out_ready)
      else $error("draw item pushed while the output stage is full");

   a_port_conflict: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("read and write of the same tile entry in one cycle");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (push.valid && push.last) |=> (state_ff == btdr_pkg::ST_IDLE))
      else $error("refresh continued after its final draw item");

   a_pend_scope: assert property (@(posedge clock) disable iff (reset)
      pend_ff.valid |-> (state_ff == btdr_pkg::ST_SCAN || state_ff == btdr_pkg::ST_FLUSH))
      else $error("held draw item outside a refresh");

endmodule

`default_nettype wire

[hdl/banked_tilemap_dirty_refresh_top.sv]
// Top level of the banked tile map with dirty marks and row refresh.
// A tile write reads the entry, then writes it back marked dirty if the value changed; a bank write
// only loads the bank register. A row refresh reads one column per cycle, set by the single read
// port of the tile memory, unless the output stalls. A screen clear walks one entry per cycle.
// Reset: synchronous; the same clearing pass runs after reset before the first item is taken.
// Depends on btdr_pkg, btdr_tile_ram and btdr_ctrl.
`default_nettype none

module banked_tilemap_dirty_refresh_top #(
   parameter int COLUMNS = btdr_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = btdr_pkg::ROWS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_cmd,
   input  wire logic [9:0] req_offset,
   input  wire logic [7:0] req_data,
   input  wire logic [4:0] req_row,
   input  wire logic       req_force_all,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_gfx_set,
   output logic [8:0]      rsp_tile_code,
   output logic [8:0]      rsp_x_pos,
   output logic [7:0]      rsp_y_pos,
   output logic            rsp_last
);

   localparam int TILE_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;

   btdr_pkg::draw_type               push;
   btdr_pkg::draw_type               rsp_ff, rsp_in;
   logic                             out_ready;
   logic                             mem_we;
   logic [ADDR_W-1:0]                mem_waddr;
   logic [btdr_pkg::ENTRY_W-1:0]     mem_wdata;
   logic                             mem_re;
   logic [ADDR_W-1:0]                mem_raddr;
   logic [btdr_pkg::ENTRY_W-1:0]     mem_rdata;

   btdr_ctrl #(
      .COLUMNS    (COLUMNS),
      .ROWS       (ROWS),
      .TILE_COUNT (TILE_COUNT),
      .ADDR_W     (ADDR_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_offset    (req_offset),
      .req_data      (req_data),
      .req_row       (req_row),
      .req_force_all (req_force_all),
      .out_ready     (out_ready),
      .push          (push),
      .mem_we        (mem_we),
      .mem_waddr     (mem_waddr),
      .mem_wdata     (mem_wdata),
      .mem_re        (mem_re),
      .mem_raddr     (mem_raddr),
      .mem_rdata     (mem_rdata)
   );

   btdr_tile_ram #(
      .DEPTH  (TILE_COUNT),
      .ADDR_W (ADDR_W),
      .DATA_W (btdr_pkg::ENTRY_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign out_ready = !rsp_ff.valid || !rsp_stall;

   always_comb begin
      rsp_in = rsp_ff;
      if (out_ready) begin
         rsp_in = push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else begin
         rsp_ff.valid <= rsp_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.gfx_set   <= rsp_in.gfx_set;
      rsp_ff.tile_code <= rsp_in.tile_code;
      rsp_ff.x_pos     <= rsp_in.x_pos;
      rsp_ff.y_pos     <= rsp_in.y_pos;
      rsp_ff.last      <= rsp_in.last;
   end

   assign rsp_valid     = rsp_ff.valid;
   assign rsp_gfx_set   = rsp_ff.gfx_set;
   assign rsp_tile_code = rsp_ff.tile_code;
   assign rsp_x_pos     = rsp_ff.x_pos;
   assign rsp_y_pos     = rsp_ff.y_pos;
   assign rsp_last      = rsp_ff.last;

endmodule

`default_nettype wire
